### hw/rtl/dlcp_pkg.sv
// Shared constants and types for the largest color path block.
`default_nettype none

package dlcp_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_EDGES  = 1024;
    localparam int NUM_COLORS = 26;

    localparam int NODE_W    = 10;
    localparam int CNT_W     = 11;
    localparam int COLOR_W   = 5;
    localparam int OP_W      = 2;
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int BPC_DEPTH = MAX_NODES * NUM_COLORS;
    localparam int BPC_AW    = $clog2(BPC_DEPTH);

    localparam logic [OP_W-1:0] OP_COLOR = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COLOR_W-1:0] color_t;

endpackage

`default_nettype wire

### hw/rtl/dlcp_if.sv
// Valid/ready channel interfaces for command and result items.
`default_nettype none

interface dlcp_in_if;
    import dlcp_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    node_t             first_node;
    node_t             second_node;
    color_t            color_code;

    modport source (output valid, operation, first_node, second_node, color_code,
                    input ready);
    modport sink   (input valid, operation, first_node, second_node, color_code,
                    output ready);
endinterface

interface dlcp_out_if;
    import dlcp_pkg::*;
    logic  valid;
    logic  ready;
    cnt_t  largest_value;
    logic  cycle_found;
    logic  edges_dropped;

    modport source (output valid, largest_value, cycle_found, edges_dropped,
                    input ready);
    modport sink   (input valid, largest_value, cycle_found, edges_dropped,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/dlcp_ram.sv
// Generic one-write one-read synchronous RAM, registered read data.
`default_nettype none

module dlcp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/dag_largest_color_path_top.sv
// Top level: graph stores and the run sequencer for the largest color path.
//
//  channel | dir | handshake            | payload
//  in_ch   | in  | valid/ready          | operation, first_node, second_node, color_code
//  out_ch  | out | valid/ready          | largest_value, cycle_found, edges_dropped
//  cfg     | in  | cfg_we (no wait)     | cfg_wdata = node_count
//
// Color and edge items are taken in IDLE. A run walks the one-write
// one-read state memories one access at a time. Reset clears control
// only; the pending and per-color stores are cleared per run and the edge
// store after it, while colors are kept. in_ch.ready is low during a run; a
// finished result waits in FINISH while the previous one is still not taken.
`default_nettype none

module dag_largest_color_path_top
    import dlcp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dlcp_in_if.sink    in_ch,
    dlcp_out_if.source out_ch,
    input  wire logic  cfg_we,
    input  wire cnt_t  cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR_PEND, S_CLR_BPC, S_DEG_RD, S_DEG_CHK, S_DEG_WR,
        S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_WAIT, S_COL, S_INC,
        S_EDGE_RD, S_EDGE_CHK, S_MRG_RD, S_MRG_WR, S_PD_RD, S_PD_WR, S_FINISH
    } state_t;

    state_t              state_reg;
    cnt_t                node_count_reg;
    cnt_t                stored_reg;
    logic                overflow_reg;
    cnt_t                n_reg;
    logic [BPC_AW-1:0]   lim_reg;
    logic [BPC_AW-1:0]   bcnt_reg;
    cnt_t                idx_reg;
    cnt_t                head_reg;
    cnt_t                tail_reg;
    node_t               node_reg;
    node_t               u_reg;
    logic [BPC_AW-1:0]   row_reg;
    logic [BPC_AW-1:0]   urow_reg;
    color_t              col_reg;
    color_t              c_reg;
    cnt_t                best_reg;
    logic                out_valid_reg;
    cnt_t                out_largest_reg;
    logic                out_cycle_reg;
    logic                out_dropped_reg;

    logic                in_fire;
    cnt_t                n_sat;

    logic                color_we;
    node_t               color_waddr;
    node_t               color_raddr;
    color_t              color_q;

    logic                edge_we;
    logic [EDGE_AW-1:0]  edge_raddr;
    logic [2*NODE_W-1:0] edge_q;
    node_t               esrc_q;
    node_t               etgt_q;

    logic                pend_we;
    node_t               pend_waddr;
    cnt_t                pend_wdata;
    node_t               pend_raddr;
    cnt_t                pend_q;

    logic                queue_we;
    node_t               queue_waddr;
    node_t               queue_wdata;
    node_t               queue_raddr;
    node_t               queue_q;

    logic                bpc_we;
    logic [BPC_AW-1:0]   bpc_waddr;
    cnt_t                bpc_wdata;
    logic [BPC_AW-1:0]   bpa_raddr;
    logic [BPC_AW-1:0]   bpb_raddr;
    cnt_t                bpa_q;
    cnt_t                bpb_q;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign in_fire              = in_ch.valid && in_ch.ready;
    assign n_sat                = (node_count_reg > CNT_W'(MAX_NODES)) ?
                                  CNT_W'(MAX_NODES) : node_count_reg;
    assign esrc_q               = edge_q[2*NODE_W-1:NODE_W];
    assign etgt_q               = edge_q[NODE_W-1:0];
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.largest_value = out_largest_reg;
    assign out_ch.cycle_found   = out_cycle_reg;
    assign out_ch.edges_dropped = out_dropped_reg;

    dlcp_ram #(.DEPTH(MAX_NODES), .WIDTH(COLOR_W)) u_color (
        .clk(clk), .we(color_we), .waddr(color_waddr), .wdata(in_ch.color_code),
        .raddr(color_raddr), .rdata(color_q));

    dlcp_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*NODE_W)) u_edge (
        .clk(clk), .we(edge_we), .waddr(stored_reg[EDGE_AW-1:0]),
        .wdata({in_ch.first_node, in_ch.second_node}),
        .raddr(edge_raddr), .rdata(edge_q));

    dlcp_ram #(.DEPTH(MAX_NODES), .WIDTH(CNT_W)) u_pend (
        .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
        .raddr(pend_raddr), .rdata(pend_q));

    dlcp_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_q));

    // two copies of the per-color maxima give two read ports
    dlcp_ram #(.DEPTH(BPC_DEPTH), .WIDTH(CNT_W)) u_bpc_a (
        .clk(clk), .we(bpc_we), .waddr(bpc_waddr), .wdata(bpc_wdata),
        .raddr(bpa_raddr), .rdata(bpa_q));

    dlcp_ram #(.DEPTH(BPC_DEPTH), .WIDTH(CNT_W)) u_bpc_b (
        .clk(clk), .we(bpc_we), .waddr(bpc_waddr), .wdata(bpc_wdata),
        .raddr(bpb_raddr), .rdata(bpb_q));

    // one access per state: each read-modify-write finishes before the next read
    always_comb
    begin
        color_we    = 1'b0;
        color_waddr = in_ch.first_node;
        color_raddr = queue_q;
        edge_we     = 1'b0;
        edge_raddr  = idx_reg[EDGE_AW-1:0];
        pend_we     = 1'b0;
        pend_waddr  = idx_reg[NODE_W-1:0];
        pend_wdata  = '0;
        pend_raddr  = idx_reg[NODE_W-1:0];
        queue_we    = 1'b0;
        queue_waddr = tail_reg[NODE_W-1:0];
        queue_wdata = idx_reg[NODE_W-1:0];
        queue_raddr = head_reg[NODE_W-1:0];
        bpc_we      = 1'b0;
        bpc_waddr   = bcnt_reg;
        bpc_wdata   = '0;
        bpa_raddr   = row_reg;
        bpb_raddr   = urow_reg;
        case (state_reg)
            S_IDLE:
            begin
                color_we = in_fire && (in_ch.operation == OP_COLOR);
                edge_we  = in_fire && (in_ch.operation == OP_EDGE) &&
                           (stored_reg < CNT_W'(MAX_EDGES));
            end
            S_CLR_PEND:
            begin
                pend_we = (idx_reg != n_reg);
            end
            S_CLR_BPC:
            begin
                bpc_we = (bcnt_reg != lim_reg);
            end
            S_DEG_CHK:
            begin
                pend_raddr = esrc_q;
            end
            S_DEG_WR:
            begin
                pend_we    = 1'b1;
                pend_waddr = u_reg;
                pend_wdata = pend_q + CNT_W'(1);
            end
            S_SCAN_CHK:
            begin
                queue_we = (pend_q == '0);
            end
            S_COL:
            begin
                bpa_raddr = row_reg + BPC_AW'(color_q);
            end
            S_INC:
            begin
                bpc_we    = 1'b1;
                bpc_waddr = row_reg + BPC_AW'(col_reg);
                bpc_wdata = bpa_q + CNT_W'(1);
            end
            S_MRG_RD:
            begin
                if (c_reg != COLOR_W'(NUM_COLORS))
                begin
                    bpa_raddr = row_reg + BPC_AW'(c_reg);
                    bpb_raddr = urow_reg + BPC_AW'(c_reg);
                end
            end
            S_MRG_WR:
            begin
                bpc_we    = (bpa_q > bpb_q);
                bpc_waddr = urow_reg + BPC_AW'(c_reg);
                bpc_wdata = bpa_q;
            end
            S_PD_RD:
            begin
                pend_raddr = u_reg;
            end
            S_PD_WR:
            begin
                pend_we     = (pend_q != '0);
                pend_waddr  = u_reg;
                pend_wdata  = pend_q - CNT_W'(1);
                queue_we    = (pend_q == CNT_W'(1));
                queue_wdata = u_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CNT_W'(1);
            stored_reg     <= '0;
            overflow_reg   <= 1'b0;
            n_reg          <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_ch.operation)
                            OP_EDGE:
                            begin
                                if (stored_reg < CNT_W'(MAX_EDGES))
                                begin
                                    stored_reg <= stored_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            OP_RUN:
                            begin
                                n_reg     <= n_sat;
                                lim_reg   <= BPC_AW'(n_sat) * BPC_AW'(NUM_COLORS);
                                idx_reg   <= '0;
                                bcnt_reg  <= '0;
                                head_reg  <= '0;
                                tail_reg  <= '0;
                                best_reg  <= '0;
                                state_reg <= S_CLR_PEND;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CLR_PEND:
                begin
                    if (idx_reg == n_reg)
                    begin
                        state_reg <= S_CLR_BPC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_CLR_BPC:
                begin
                    if (bcnt_reg == lim_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DEG_RD;
                    end
                    else
                    begin
                        bcnt_reg <= bcnt_reg + BPC_AW'(1);
                    end
                end
                S_DEG_RD:
                begin
                    if (idx_reg == stored_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= S_DEG_CHK;
                    end
                end
                S_DEG_CHK:
                begin
                    if ((CNT_W'(esrc_q) < n_reg) && (CNT_W'(etgt_q) < n_reg))
                    begin
                        u_reg     <= esrc_q;
                        state_reg <= S_DEG_WR;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_DEG_RD;
                    end
                end
                S_DEG_WR:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_DEG_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= (idx_reg == n_reg) ? S_POP : S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (pend_q == '0)
                    begin
                        tail_reg <= tail_reg + CNT_W'(1);
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_SCAN_RD;
                end
                S_POP:
                begin
                    state_reg <= (head_reg == tail_reg) ? S_FINISH : S_POP_WAIT;
                end
                S_POP_WAIT:
                begin
                    node_reg  <= queue_q;
                    row_reg   <= BPC_AW'(queue_q) * BPC_AW'(NUM_COLORS);
                    head_reg  <= head_reg + CNT_W'(1);
                    state_reg <= S_COL;
                end
                S_COL:
                begin
                    idx_reg <= '0;
                    if (color_q < COLOR_W'(NUM_COLORS))
                    begin
                        col_reg   <= color_q;
                        state_reg <= S_INC;
                    end
                    else
                    begin
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_INC:
                begin
                    if ((bpa_q + CNT_W'(1)) > best_reg)
                    begin
                        best_reg <= bpa_q + CNT_W'(1);
                    end
                    state_reg <= S_EDGE_RD;
                end
                S_EDGE_RD:
                begin
                    state_reg <= (idx_reg == stored_reg) ? S_POP : S_EDGE_CHK;
                end
                S_EDGE_CHK:
                begin
                    if ((etgt_q == node_reg) && (CNT_W'(esrc_q) < n_reg))
                    begin
                        u_reg     <= esrc_q;
                        urow_reg  <= BPC_AW'(esrc_q) * BPC_AW'(NUM_COLORS);
                        c_reg     <= '0;
                        state_reg <= S_MRG_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_EDGE_RD;
                    end
                end
                S_MRG_RD:
                begin
                    state_reg <= (c_reg == COLOR_W'(NUM_COLORS)) ? S_PD_RD : S_MRG_WR;
                end
                S_MRG_WR:
                begin
                    c_reg     <= c_reg + COLOR_W'(1);
                    state_reg <= S_MRG_RD;
                end
                S_PD_RD:
                begin
                    state_reg <= S_PD_WR;
                end
                S_PD_WR:
                begin
                    if (pend_q == CNT_W'(1))
                    begin
                        tail_reg <= tail_reg + CNT_W'(1);
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_EDGE_RD;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_cycle_reg   <= (head_reg != n_reg);
                        out_largest_reg <= (head_reg != n_reg) ? '0 : best_reg;
                        out_dropped_reg <= overflow_reg;
                        stored_reg      <= '0;
                        overflow_reg    <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_le_n: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= n_reg)
        else $error("more nodes queued than in use");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (stored_reg == '0) && !overflow_reg)
        else $error("edge store not cleared after run");

    a_cycle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cycle_reg |-> (out_largest_reg == '0))
        else $error("nonzero value reported with cycle");

endmodule

`default_nettype wire

### tb/dlcp_checker.sv
// Checker: watches the command, result and configuration ports, predicts results and compares.
`timescale 1ns / 100ps

module dlcp_checker
    import dlcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dlcp_in_if        in_mon,
    dlcp_out_if       out_mon,
    input  wire logic cfg_we,
    input  wire cnt_t cfg_wdata,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        cnt_t largest;
        logic cycle;
        logic dropped;
    } path_result_t;

    path_result_t expected_paths[$];

    cnt_t    used_nodes;
    color_t  color_of [MAX_NODES];
    node_t   src_of [MAX_EDGES];
    node_t   dst_of [MAX_EDGES];
    int      edge_total;
    logic    overflowed;
    int      out_left [MAX_NODES];
    int      color_best [MAX_NODES * NUM_COLORS];

    assign pending = expected_paths.size();

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic path_result_t longest_color_path();
        int n;
        int ne;
        int best;
        int left;
        int node;
        int u;
        int col;
        int order[$];
        path_result_t r;
        n = (used_nodes > MAX_NODES) ? MAX_NODES : int'(used_nodes);
        ne = edge_total;
        best = 0;
        left = n;
        for (int v = 0; v < n; v++)
            out_left[v] = 0;
        for (int i = 0; i < n * NUM_COLORS; i++)
            color_best[i] = 0;
        for (int e = 0; e < ne; e++)
            if (src_of[e] < n && dst_of[e] < n)
                out_left[src_of[e]]++;
        for (int v = 0; v < n; v++)
            if (out_left[v] == 0)
                order.insert(order.size(), v);
        while (order.size() > 0)
        begin
            node = order.pop_front();
            left--;
            col = color_of[node];
            if (col < NUM_COLORS)
            begin
                color_best[node * NUM_COLORS + col]++;
                if (color_best[node * NUM_COLORS + col] > best)
                    best = color_best[node * NUM_COLORS + col];
            end
            for (int e = 0; e < ne; e++)
            begin
                u = src_of[e];
                if (dst_of[e] != node || u >= n)
                    continue;
                for (int c = 0; c < NUM_COLORS; c++)
                    if (color_best[node * NUM_COLORS + c] > color_best[u * NUM_COLORS + c])
                        color_best[u * NUM_COLORS + c] = color_best[node * NUM_COLORS + c];
                if (out_left[u] > 0)
                begin
                    out_left[u]--;
                    if (out_left[u] == 0)
                        order.insert(order.size(), u);
                end
            end
        end
        r.largest = (left > 0) ? '0 : cnt_t'(best);
        r.cycle   = (left > 0);
        r.dropped = overflowed;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_nodes = 1;
            edge_total = 0;
            overflowed = 1'b0;
            expected_paths.delete();
        end
        else
        begin
            path_result_t want;
            if (cfg_we)
                used_nodes = cfg_wdata;
            if (in_mon.valid && in_mon.ready)
            begin
                case (in_mon.operation)
                    OP_COLOR: color_of[in_mon.first_node] = in_mon.color_code;
                    OP_EDGE:
                    begin
                        if (edge_total < MAX_EDGES)
                        begin
                            src_of[edge_total] = in_mon.first_node;
                            dst_of[edge_total] = in_mon.second_node;
                            edge_total++;
                        end
                        else
                            overflowed = 1'b1;
                    end
                    OP_RUN:
                    begin
                        expected_paths.insert(expected_paths.size(), longest_color_path());
                        edge_total = 0;
                        overflowed = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_paths.size() == 0)
                    report("unexpected result", out_mon.largest_value, -1);
                else
                begin
                    want = expected_paths.pop_front();
                    if (out_mon.largest_value !== want.largest)
                        report("largest_value", out_mon.largest_value, want.largest);
                    if (out_mon.cycle_found !== want.cycle)
                        report("cycle_found", out_mon.cycle_found, want.cycle);
                    if (out_mon.edges_dropped !== want.dropped)
                        report("edges_dropped", out_mon.edges_dropped, want.dropped);
                end
            end
        end
    end

endmodule

### tb/testbench.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
    import dlcp_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cnt_t cfg_wdata;
    int   fail_count;
    int   pending;
    int   phase;
    int   random_items;
    bit   colored [MAX_NODES];

    dlcp_in_if  in_ch ();
    dlcp_out_if out_ch ();

    dag_largest_color_path_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    dlcp_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("testbench failed");
        $finish;
    end

    // result back-pressure per phase: none, none, 70 percent stall, 6 percent stall
    always @(posedge clk)
    begin
        case (phase)
            2:       out_ch.ready <= ($urandom_range(99) >= 70);
            3:       out_ch.ready <= ($urandom_range(99) >= 6);
            default: out_ch.ready <= 1'b1;
        endcase
    end

    task automatic send(input logic [OP_W-1:0] op, input int a, input int b, input int c);
        int idle_pct;
        idle_pct = (phase == 1) ? 70 : (phase == 3) ? 6 : 0;
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.first_node  <= node_t'(a);
        in_ch.second_node <= node_t'(b);
        in_ch.color_code  <= color_t'(c);
        if (op == OP_COLOR)
            colored[a] = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_nodes(input int n);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt_t'(n);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic color_missing(input int n);
        int lim;
        lim = (n > MAX_NODES) ? MAX_NODES : n;
        for (int v = 0; v < lim; v++)
            if (!colored[v])
                send(OP_COLOR, v, $urandom_range(1023), $urandom_range(31));
    endtask

    initial
    begin
        int n;
        int ne;
        int a;
        int b;
        phase             = 0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_COLOR;
        in_ch.first_node  = '0;
        in_ch.second_node = '0;
        in_ch.color_code  = '0;
        out_ch.ready      = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single node at reset size, then empty graph
        send(OP_COLOR, 0, 0, 0);
        send(OP_RUN, 0, 0, 0);
        send(OP_NONE, 1023, 1023, 31);
        set_nodes(0);
        send(OP_RUN, 1023, 1023, 31);
        // chain with duplicate edge, an out-of-range color, edges outside used nodes
        set_nodes(3);
        send(OP_COLOR, 0, 0, 25);
        send(OP_COLOR, 1, 0, 26);
        send(OP_COLOR, 2, 0, 25);
        send(OP_EDGE, 0, 1, 0);
        send(OP_EDGE, 1, 2, 0);
        send(OP_EDGE, 0, 1, 0);
        send(OP_EDGE, 2, 1023, 0);
        send(OP_EDGE, 1023, 0, 0);
        send(OP_RUN, 0, 0, 0);
        // two-node cycle, then self loop
        set_nodes(2);
        send(OP_EDGE, 0, 1, 0);
        send(OP_EDGE, 1, 0, 0);
        send(OP_RUN, 0, 0, 0);
        send(OP_EDGE, 1, 1, 0);
        send(OP_RUN, 0, 0, 0);
        send(OP_COLOR, 1023, 0, 31);

        // full node range, then a size above range
        set_nodes(MAX_NODES);
        color_missing(MAX_NODES);
        send(OP_EDGE, 1022, 1023, 0);
        send(OP_EDGE, 0, 1023, 0);
        send(OP_RUN, 0, 0, 0);
        set_nodes(2047);
        send(OP_EDGE, 5, 6, 0);
        send(OP_RUN, 0, 0, 0);

        // edge store overflow
        set_nodes(4);
        for (int i = 0; i < MAX_EDGES + 3; i++)
        begin
            a = $urandom_range(2);
            send(OP_EDGE, a, $urandom_range(3, a + 1), 0);
        end
        send(OP_RUN, 0, 0, 0);
        send(OP_EDGE, 0, 1, 0);
        send(OP_RUN, 0, 0, 0);

        random_items = 0;
        while (random_items < 1350)
        begin
            phase = (random_items / 170) % 4;
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
            set_nodes(n);
            color_missing(n);
            repeat ($urandom_range(4))
            begin
                send(OP_COLOR, $urandom_range(n - 1), 0, $urandom_range(31));
                random_items++;
            end
            ne = $urandom_range(2 * n);
            for (int i = 0; i < ne; i++)
            begin
                case ($urandom_range(19))
                    0:       send(OP_EDGE, $urandom_range(1023), $urandom_range(1023), 0);
                    1, 2:    send(OP_EDGE, $urandom_range(n - 1), $urandom_range(n - 1), 0);
                    3:       send(OP_NONE, $urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(31));
                    default:
                    begin
                        if (n > 1)
                        begin
                            a = $urandom_range(n - 2);
                            b = $urandom_range(n - 1, a + 1);
                            send(OP_EDGE, a, b, $urandom_range(31));
                        end
                        else
                            send(OP_EDGE, 0, $urandom_range(1023, 1), 0);
                    end
                endcase
                random_items++;
            end
            send(OP_RUN, $urandom_range(1023), $urandom_range(1023), $urandom_range(31));
            random_items++;
        end

        settle();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
